// ===== sv/rhr_pkg.sv =====
// ----------------------------------------------------------------------------
// rhr_pkg: shared types and constants for the hue rotation pipeline
// Stage record carried down the pipe, channel and sextant codes, and the
// fixed angles used to build and rebuild the hue.
// ----------------------------------------------------------------------------
package rhr_pkg;

  localparam logic [9:0] DEG_60   = 10'd60;
  localparam logic [9:0] DEG_120  = 10'd120;
  localparam logic [9:0] DEG_180  = 10'd180;
  localparam logic [9:0] DEG_240  = 10'd240;
  localparam logic [9:0] DEG_300  = 10'd300;
  localparam logic [9:0] DEG_FULL = 10'd360;

  // floor(v / 15) == (v * RECIP15) >> 16 for every v below 4681
  localparam logic [23:0] RECIP15 = 24'd4370;

  // which channel holds the maximum (red wins ties over green, green over blue)
  typedef enum logic [1:0] {
    SEL_RED   = 2'd0,
    SEL_GREEN = 2'd1,
    SEL_BLUE  = 2'd2
  } sel_t;

  // sextant of the rotated hue
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  lo;
    logic [7:0]  dif;
    logic [8:0]  shift;
    logic        bypass;
    sel_t        sel;
    logic        neg;
    logic [13:0] rem;
    logic [13:0] dsh;
    logic [5:0]  quot;
    logic [8:0]  hue;
    sector_t     sector;
    logic [13:0] prod;
  } stage_t;

endpackage

// ===== sv/rhr_front.sv =====
// ----------------------------------------------------------------------------
// rhr_front: input stage
// Finds max, min and spread, picks the channel of the maximum, and forms the
// scaled hue numerator as magnitude and sign for the divider chain.
// ----------------------------------------------------------------------------
module rhr_front
  import rhr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic [7:0] alpha_in,
  input  logic [8:0] shift,
  input  logic       ready_dn,
  output logic       ready_up,
  output logic       vld,
  output stage_t     q
);

  logic [7:0]  lo;
  logic [7:0]  hi;
  logic [7:0]  dif;
  logic [7:0]  mag;
  logic        neg;
  sel_t        sel;
  logic [13:0] num;
  stage_t      q_next;

  always_comb begin
    lo = red_in;
    if (green_in < lo) lo = green_in;
    if (blue_in < lo) lo = blue_in;
    hi = red_in;
    if (green_in > hi) hi = green_in;
    if (blue_in > hi) hi = blue_in;
    dif = hi - lo;

    if (hi == red_in) begin
      sel = SEL_RED;
      neg = green_in < blue_in;
      mag = neg ? blue_in - green_in : green_in - blue_in;
    end else if (hi == green_in) begin
      sel = SEL_GREEN;
      neg = blue_in < red_in;
      mag = neg ? red_in - blue_in : blue_in - red_in;
    end else begin
      sel = SEL_BLUE;
      neg = red_in < green_in;
      mag = neg ? green_in - red_in : red_in - green_in;
    end

    // mag * 60 as 64 - 4
    num = ({6'b0, mag} << 6) - ({6'b0, mag} << 2);

    q_next        = '0;
    q_next.red    = red_in;
    q_next.green  = green_in;
    q_next.blue   = blue_in;
    q_next.alpha  = alpha_in;
    q_next.lo     = lo;
    q_next.dif    = dif;
    q_next.shift  = shift;
    q_next.bypass = (shift == 9'd0) || (dif == 8'd0);
    q_next.sel    = sel;
    q_next.neg    = neg;
    q_next.rem    = num;
    q_next.dsh    = {1'b0, dif, 5'b0};
    q_next.quot   = '0;
  end

  assign ready_up = !vld || ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ready_up) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && in_valid) begin
      q <= q_next;
    end
  end

endmodule

// ===== sv/rhr_div_cell.sv =====
// ----------------------------------------------------------------------------
// rhr_div_cell: one restoring division step
// Compares the partial remainder with the shifted spread, subtracts when it
// fits, shifts one quotient bit in and halves the divisor for the next cell.
// ----------------------------------------------------------------------------
module rhr_div_cell
  import rhr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   v_in,
  input  stage_t d_in,
  input  logic   ready_dn,
  output logic   ready_up,
  output logic   vld,
  output stage_t q
);

  logic   fits;
  stage_t q_next;

  always_comb begin
    fits        = d_in.rem >= d_in.dsh;
    q_next      = d_in;
    q_next.rem  = fits ? d_in.rem - d_in.dsh : d_in.rem;
    q_next.quot = {d_in.quot[4:0], fits};
    q_next.dsh  = d_in.dsh >> 1;
  end

  assign ready_up = !vld || ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ready_up) begin
      vld <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && v_in) begin
      q <= q_next;
    end
  end

endmodule

// ===== sv/rhr_hue.sv =====
// ----------------------------------------------------------------------------
// rhr_hue: hue build, rotation and sextant scaling
// First register: signed quotient plus sextant offset, plus shift, wrapped
// by 360. Second register: sextant of the rotated hue and spread * offset.
// ----------------------------------------------------------------------------
module rhr_hue
  import rhr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   v_in,
  input  stage_t d_in,
  input  logic   ready_dn,
  output logic   ready_up,
  output logic   vld,
  output stage_t q
);

  logic       vld_a;
  stage_t     a;
  stage_t     a_next;
  logic       ready_a;
  logic [9:0] quot_w;
  logic [9:0] hraw;
  logic [9:0] hsum;
  logic [9:0] hmod;
  logic [9:0] hw;
  logic [9:0] tw;
  sector_t    sector;
  stage_t     q_next;

  always_comb begin
    quot_w = {4'b0, d_in.quot};
    case (d_in.sel)
      SEL_RED: begin
        // wrap a negative hue by a full turn
        hraw = (d_in.neg && (d_in.quot != 6'd0)) ? DEG_FULL - quot_w : quot_w;
      end
      SEL_GREEN: begin
        hraw = d_in.neg ? DEG_120 - quot_w : DEG_120 + quot_w;
      end
      SEL_BLUE: begin
        hraw = d_in.neg ? DEG_240 - quot_w : DEG_240 + quot_w;
      end
      default: begin
        hraw = '0;
      end
    endcase
    hsum       = hraw + {1'b0, d_in.shift};
    hmod       = (hsum >= DEG_FULL) ? hsum - DEG_FULL : hsum;
    a_next     = d_in;
    a_next.hue = hmod[8:0];
  end

  always_comb begin
    hw = {1'b0, a.hue};
    if (hw < DEG_60) begin
      sector = SEC_0;
      tw     = hw;
    end else if (hw < DEG_120) begin
      sector = SEC_1;
      tw     = DEG_120 - hw;
    end else if (hw < DEG_180) begin
      sector = SEC_2;
      tw     = hw - DEG_120;
    end else if (hw < DEG_240) begin
      sector = SEC_3;
      tw     = DEG_240 - hw;
    end else if (hw < DEG_300) begin
      sector = SEC_4;
      tw     = hw - DEG_240;
    end else begin
      sector = SEC_5;
      tw     = DEG_FULL - hw;
    end
    q_next        = a;
    q_next.sector = sector;
    q_next.prod   = {6'b0, a.dif} * {8'b0, tw[5:0]};
  end

  assign ready_a  = !vld || ready_dn;
  assign ready_up = !vld_a || ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld   <= 1'b0;
    end else begin
      if (ready_up) vld_a <= v_in;
      if (ready_a) vld <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && v_in) begin
      a <= a_next;
    end
    if (ready_a && vld_a) begin
      q <= q_next;
    end
  end

endmodule

// ===== sv/rhr_out.sv =====
// ----------------------------------------------------------------------------
// rhr_out: channel rebuild and output register
// Divides the scaled offset by 60 through a shift and a reciprocal multiply,
// adds the minimum, places max, min and ramp by sextant unless bypassed.
// ----------------------------------------------------------------------------
module rhr_out
  import rhr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   v_in,
  input  stage_t d_in,
  input  logic   ready_dn,
  output logic   ready_up,
  output logic   vld,
  output stage_t q
);

  logic [11:0] quarter;
  logic [23:0] scaled;
  logic [7:0]  ramp;
  logic [7:0]  hi;
  logic [7:0]  lo;
  stage_t      q_next;

  always_comb begin
    // x / 60 == (x / 4) / 15
    quarter = d_in.prod[13:2];
    scaled  = {12'b0, quarter} * RECIP15;
    lo      = d_in.lo;
    hi      = d_in.lo + d_in.dif;
    ramp    = d_in.lo + scaled[23:16];
    q_next  = d_in;
    if (!d_in.bypass) begin
      case (d_in.sector)
        SEC_0: begin
          q_next.red = hi;   q_next.green = ramp; q_next.blue = lo;
        end
        SEC_1: begin
          q_next.red = ramp; q_next.green = hi;   q_next.blue = lo;
        end
        SEC_2: begin
          q_next.red = lo;   q_next.green = hi;   q_next.blue = ramp;
        end
        SEC_3: begin
          q_next.red = lo;   q_next.green = ramp; q_next.blue = hi;
        end
        SEC_4: begin
          q_next.red = ramp; q_next.green = lo;   q_next.blue = hi;
        end
        SEC_5: begin
          q_next.red = hi;   q_next.green = lo;   q_next.blue = ramp;
        end
        default: begin
          q_next.red = d_in.red; q_next.green = d_in.green; q_next.blue = d_in.blue;
        end
      endcase
    end
  end

  assign ready_up = !vld || ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ready_up) begin
      vld <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && v_in) begin
      q <= q_next;
    end
  end

endmodule

// ===== sv/rgb_hue_rotate_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_hue_rotate_unit: RGBA hue rotation
// Rotates the hue of each pixel by the configured shift; alpha passes through.
// ----------------------------------------------------------------------------
// Stages, in order: front stage, six restoring divider cells, two hue stages,
// output register.
// Throughput: one pixel per clock while out_stall is low; each stage holds
// its beat only while the next one is full and stalled, so bubbles close up.
// Reset: synchronous, clears all stage valids and sets the shift to zero.
module rgb_hue_rotate_unit
  import rhr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] hue_shift,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic [7:0] alpha_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic [7:0] alpha_out
);

  localparam int NCELL = 6;

  logic [8:0] shift;
  logic [9:0] shift_w;

  logic   front_vld;
  logic   front_ready;
  stage_t front_q;

  logic   cell_vld   [NCELL];
  logic   cell_ready [NCELL];
  stage_t cell_q     [NCELL];

  logic   hue_vld;
  logic   hue_ready;
  stage_t hue_q;

  logic   out_ready;
  stage_t out_q;

  // hold the shift already reduced modulo 360
  assign cfg_ready = 1'b1;
  assign shift_w   = {1'b0, hue_shift};

  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= '0;
    end else if (cfg_valid) begin
      shift <= (shift_w >= DEG_FULL) ? 9'(shift_w - DEG_FULL) : hue_shift;
    end
  end

  rhr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .alpha_in (alpha_in),
    .shift    (shift),
    .ready_dn (cell_ready[0]),
    .ready_up (front_ready),
    .vld      (front_vld),
    .q        (front_q)
  );

  assign in_stall = !front_ready;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == 0) begin : g_first
      rhr_div_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .v_in     (front_vld),
        .d_in     (front_q),
        .ready_dn ((i == NCELL - 1) ? hue_ready : cell_ready[(i + 1) % NCELL]),
        .ready_up (cell_ready[i]),
        .vld      (cell_vld[i]),
        .q        (cell_q[i])
      );
    end else begin : g_next
      rhr_div_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .v_in     (cell_vld[i - 1]),
        .d_in     (cell_q[i - 1]),
        .ready_dn ((i == NCELL - 1) ? hue_ready : cell_ready[(i + 1) % NCELL]),
        .ready_up (cell_ready[i]),
        .vld      (cell_vld[i]),
        .q        (cell_q[i])
      );
    end
  end

  rhr_hue u_hue (
    .clk      (clk),
    .rst      (rst),
    .v_in     (cell_vld[NCELL - 1]),
    .d_in     (cell_q[NCELL - 1]),
    .ready_dn (out_ready),
    .ready_up (hue_ready),
    .vld      (hue_vld),
    .q        (hue_q)
  );

  rhr_out u_out (
    .clk      (clk),
    .rst      (rst),
    .v_in     (hue_vld),
    .d_in     (hue_q),
    .ready_dn (!out_stall),
    .ready_up (out_ready),
    .vld      (out_valid),
    .q        (out_q)
  );

  assign red_out   = out_q.red;
  assign green_out = out_q.green;
  assign blue_out  = out_q.blue;
  assign alpha_out = out_q.alpha;

endmodule
